@@ design/lifo_pkg.sv @@
// Shared types and constants of the bounded LIFO stack.
`default_nettype none

package lifo_pkg;

  // Sizing
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned CAP_RESET = 16;

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_TOP    = 3'd3,
    ACT_BOTTOM = 3'd4
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_e;

  // Input word
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] push_value;
    logic [POS_W-1:0]         position;
  } lifo_in_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
    logic                     is_full;
  } lifo_out_t;

  // Shift control broadcast along the cell row
  typedef struct packed {
    logic push;
    logic pop;
  } lifo_shift_t;

endpackage : lifo_pkg

`default_nettype wire

@@ design/bounded_lifo_stack_unit.sv @@
// Top level of the bounded LIFO stack: cell row, fill count and result register.
`default_nettype none

// Bounded last-in-first-out stack of signed 32-bit words held in a row of
// cells, cell 0 being the top. A push shifts every cell one place down and
// loads the new word into cell 0; a pop shifts every cell one place up. The
// bottom entry is mirrored in a register of its own, and a peek selects one
// cell through a decoded OR-reduction. Each accepted word is resolved in the
// cycle it is accepted and its result lands in the output register, so the
// block takes one word per clock cycle as long as the result side keeps
// taking. Every word yields exactly one result. The user must write the
// capacity through cfg_we_i/cfg_wdata_i only while the block is idle; the
// block does not enforce it. Zero acts as one, above the depth as the depth.

module bounded_lifo_stack_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire lifo_pkg::lifo_in_t          in_word_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output lifo_pkg::lifo_out_t              out_word_o,
  input  wire                              cfg_we_i,
  input  wire logic [lifo_pkg::CAP_W-1:0]  cfg_wdata_i
);

  localparam int unsigned DEPTH  = lifo_pkg::DEPTH;
  localparam int unsigned DATA_W = lifo_pkg::DATA_W;
  localparam int unsigned CNT_W  = lifo_pkg::CNT_W;

  logic [lifo_pkg::CAP_W-1:0] capacity_q;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [DATA_W-1:0]          bottom_q, bottom_d;
  logic                       out_valid_q;
  lifo_pkg::lifo_out_t        out_word_q, out_word_d;

  logic                       in_fire;
  logic [CNT_W-1:0]           eff_cap;
  logic                       full_now;
  logic                       pos_ok;
  lifo_pkg::lifo_shift_t      shift;
  logic [DATA_W-1:0]          peek_val;
  logic [DATA_W-1:0]          rd_val;
  lifo_pkg::status_e          status;

  logic [DEPTH-1:0]           sel;
  logic [DATA_W-1:0]          cell_data [DEPTH];
  logic [DATA_W-1:0]          cell_peek [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lifo_pkg::CAP_W'(lifo_pkg::CAP_RESET);
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Effective capacity: zero acts as one, saturate at the depth
  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(capacity_q) > 32'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(capacity_q);
    end
  end

  assign full_now = (count_q >= eff_cap);
  assign pos_ok   = (in_word_i.position != '0) &&
                    (32'(in_word_i.position) <= 32'(count_q));

  // Peek select decode, position 1 is cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_sel
    assign sel[i] = (32'(in_word_i.position) == 32'(i + 1));
  end

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] upper, lower;
    if (i == 0) begin : g_top
      assign upper = DATA_W'(in_word_i.push_value);
    end else begin : g_mid
      assign upper = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign lower = '0;
    end else begin : g_inner
      assign lower = cell_data[i+1];
    end

    lifo_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .upper_i (upper),
      .lower_i (lower),
      .sel_i   (sel[i]),
      .data_o  (cell_data[i]),
      .peek_o  (cell_peek[i])
    );
  end

  // OR-reduce the masked cell outputs
  always_comb begin
    peek_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      peek_val = peek_val | cell_peek[i];
    end
  end

  // Action decode
  always_comb begin
    shift    = '0;
    count_d  = count_q;
    bottom_d = bottom_q;
    rd_val   = '0;
    status   = lifo_pkg::ST_OK;
    unique case (in_word_i.action)
      lifo_pkg::ACT_PUSH: begin
        if (full_now) begin
          status = lifo_pkg::ST_OVERFLOW;
          rd_val = '1;
        end else begin
          shift.push = in_fire;
          count_d    = count_q + CNT_W'(1);
          if (count_q == '0) begin
            bottom_d = DATA_W'(in_word_i.push_value);
          end
        end
      end
      lifo_pkg::ACT_POP: begin
        if (count_q == '0) begin
          status = lifo_pkg::ST_UNDERFLOW;
          rd_val = '1;
        end else begin
          shift.pop = in_fire;
          count_d   = count_q - CNT_W'(1);
          rd_val    = cell_data[0];
        end
      end
      lifo_pkg::ACT_PEEK: begin
        if (!pos_ok) begin
          status = lifo_pkg::ST_BAD_POS;
          rd_val = '1;
        end else begin
          rd_val = peek_val;
        end
      end
      lifo_pkg::ACT_TOP: begin
        if (count_q == '0) begin
          status = lifo_pkg::ST_UNDERFLOW;
          rd_val = '1;
        end else begin
          rd_val = cell_data[0];
        end
      end
      lifo_pkg::ACT_BOTTOM: begin
        if (count_q == '0) begin
          status = lifo_pkg::ST_UNDERFLOW;
          rd_val = '1;
        end else begin
          rd_val = bottom_q;
        end
      end
      default: begin
        // unused codes: no operation
      end
    endcase
  end

  // Result word
  always_comb begin
    out_word_d.read_value = rd_val;
    out_word_d.status     = status;
    out_word_d.fill_count = lifo_pkg::FILL_W'(count_d);
    out_word_d.is_empty   = (count_d == '0);
    out_word_d.is_full    = (count_d >= eff_cap);
  end

  // Fill count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bottom_q   <= bottom_d;
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Fill count never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("fill count above depth");

  // A successful push raises the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_word_i.action == lifo_pkg::ACT_PUSH && !full_now
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not advance count");

  // A successful pop returns the old top word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_word_i.action == lifo_pkg::ACT_POP && count_q != '0
    |=> out_word_o.read_value == $past(cell_data[0]))
    else $error("pop returned wrong word");

  // An overflow result always reports full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == lifo_pkg::ST_OVERFLOW |-> out_word_o.is_full)
    else $error("overflow without full flag");

  // Bottom mirror matches the deepest cell while the stack holds one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'(1) |-> bottom_q == cell_data[0])
    else $error("bottom mirror out of step");

endmodule : bounded_lifo_stack_unit

`default_nettype wire

@@ design/lifo_cell.sv @@
// One stack cell: holds one entry, shifts down on push and up on pop.
`default_nettype none

module lifo_cell (
  input  wire                              clk_i,
  input  wire lifo_pkg::lifo_shift_t       shift_i,
  input  wire logic [lifo_pkg::DATA_W-1:0] upper_i,
  input  wire logic [lifo_pkg::DATA_W-1:0] lower_i,
  input  wire logic                        sel_i,
  output logic [lifo_pkg::DATA_W-1:0]      data_o,
  output logic [lifo_pkg::DATA_W-1:0]      peek_o
);

  logic [lifo_pkg::DATA_W-1:0] data_q;

  // Entry register: take the word from above on push, from below on pop
  always_ff @(posedge clk_i) begin
    if (shift_i.push) begin
      data_q <= upper_i;
    end else if (shift_i.pop) begin
      data_q <= lower_i;
    end
  end

  assign data_o = data_q;

  // Masked copy for the peek OR-reduction
  assign peek_o = sel_i ? data_q : '0;

endmodule : lifo_cell

`default_nettype wire

@@ tb/bounded_lifo_stack_unit_tb.sv @@
// Self-checking testbench of the bounded LIFO stack unit.
`default_nettype none

module bounded_lifo_stack_unit_tb;
  import lifo_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_LIMIT     = 5000;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned PHASE_WORDS     = 190;

  // Action codes the block treats as no operation
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  // Shadow of the stack: predicts each result and checks it in order
  class stack_scoreboard;
    logic signed [DATA_W-1:0] entries[DEPTH];
    int unsigned              fill = 0;
    logic [CAP_W-1:0]         capacity = CAP_W'(CAP_RESET);
    lifo_out_t                pending_results[$];
    int unsigned              errors = 0;

    function automatic lifo_out_t predict_result(lifo_in_t w);
      lifo_out_t   r;
      int unsigned cap;
      int unsigned pos;
      cap = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
      pos = w.position;
      r = '0;
      r.status = ST_OK;
      case (w.action)
        ACT_PUSH: begin
          if (fill >= cap) begin
            r.status = ST_OVERFLOW;
            r.read_value = '1;
          end else begin
            entries[fill] = w.push_value;
            fill++;
          end
        end
        ACT_POP: begin
          if (fill == 0) begin
            r.status = ST_UNDERFLOW;
            r.read_value = '1;
          end else begin
            fill--;
            r.read_value = entries[fill];
          end
        end
        ACT_PEEK: begin
          if (pos == 0 || pos > fill) begin
            r.status = ST_BAD_POS;
            r.read_value = '1;
          end else begin
            r.read_value = entries[fill - pos];
          end
        end
        ACT_TOP, ACT_BOTTOM: begin
          if (fill == 0) begin
            r.status = ST_UNDERFLOW;
            r.read_value = '1;
          end else begin
            r.read_value = (w.action == ACT_TOP) ? entries[fill - 1] : entries[0];
          end
        end
        default: ;  // unused codes leave the stack alone
      endcase
      r.fill_count = FILL_W'(fill);
      r.is_empty   = (fill == 0);
      r.is_full    = (fill >= cap);
      return r;
    endfunction

    function automatic void note_accepted(lifo_in_t w);
      pending_results.push_back(predict_result(w));
    endfunction

    function automatic void flag(string what, lifo_out_t exp_w, lifo_out_t got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0s: expected value %0d status %0d fill %0d empty %0b full %0b,",
                 what, exp_w.read_value, exp_w.status, exp_w.fill_count,
                 exp_w.is_empty, exp_w.is_full);
        $display("  got value %0d status %0d fill %0d empty %0b full %0b",
                 got.read_value, got.status, got.fill_count, got.is_empty,
                 got.is_full);
      end
    endfunction

    function automatic void check_result(lifo_out_t got);
      lifo_out_t exp_w;
      if (pending_results.size() == 0) begin
        flag("result with no word outstanding", '0, got);
        return;
      end
      exp_w = pending_results.pop_front();
      if (got.read_value !== exp_w.read_value || got.status !== exp_w.status ||
          got.fill_count !== exp_w.fill_count || got.is_empty !== exp_w.is_empty ||
          got.is_full !== exp_w.is_full)
        flag("result mismatch", exp_w, got);
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  lifo_in_t         in_word_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  lifo_out_t        out_word_o;
  logic             cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;

  bit               hold_off_req = 1'b0;
  stack_scoreboard  sb = new();

  bounded_lifo_stack_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Monitor: handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_accepted(in_word_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_word_o);
    end
  end

  function automatic lifo_in_t mk_word(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val,
                                       logic [POS_W-1:0] pos);
    lifo_in_t w;
    w.action     = act;
    w.push_value = val;
    w.position   = pos;
    return w;
  endfunction

  // Random word; peeks lean towards positions that are currently held
  function automatic lifo_in_t random_word(int unsigned push_pct);
    lifo_in_t    w;
    int unsigned r;
    w.push_value = $urandom;
    case ($urandom_range(0, 7))
      0: w.push_value = 32'h7fff_ffff;
      1: w.push_value = 32'h8000_0000;
      2: w.push_value = $urandom_range(0, 3) - 2;
      default: ;
    endcase
    if (sb.fill > 0 && $urandom_range(0, 9) < 6)
      w.position = POS_W'($urandom_range(1, sb.fill));
    else
      w.position = POS_W'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      w.action = ACT_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45)      w.action = ACT_POP;
      else if (r < 70) w.action = ACT_PEEK;
      else if (r < 82) w.action = ACT_TOP;
      else if (r < 94) w.action = ACT_BOTTOM;
      else if (r < 96) w.action = ACT_UNUSED_LO;
      else if (r < 98) w.action = ACT_UNUSED_MID;
      else             w.action = ACT_UNUSED_HI;
    end
    return w;
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(lifo_in_t w);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Capacity write once every outstanding result is back
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    pause_sender(1);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.capacity = cap;
  endtask

  // Bursts of random words, each burst with its own push bias
  task automatic run_random(int unsigned n_words, bit with_gaps);
    int unsigned sent;
    int unsigned burst;
    int unsigned push_pct;
    sent = 0;
    while (sent < n_words) begin
      burst    = $urandom_range(1, 24);
      push_pct = $urandom_range(15, 80);
      repeat (burst) begin
        if (sent < n_words) begin
          send_word(random_word(push_pct));
          sent++;
        end
      end
      if (with_gaps && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  // Receiver: ready pattern changes after each random span; honours a long hold-off
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        if (hold_off_req) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
          hold_off_req = 1'b0;
        end else begin
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            2: out_ready_i <= (tick % 3 == 0);
            default: out_ready_i <= ($urandom_range(0, 9) < 8);
          endcase
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [CAP_W-1:0] caps[10];
    int unsigned      waited;
    caps = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd0, 5'd17, 5'd10, 5'd2, 5'd16, 5'd30};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-stack errors, extreme values, every action
    send_word(mk_word(ACT_POP, 32'd5, 5'd1));
    send_word(mk_word(ACT_TOP, 32'd0, 5'd1));
    send_word(mk_word(ACT_BOTTOM, 32'd0, 5'd1));
    send_word(mk_word(ACT_PEEK, 32'd0, 5'd1));
    send_word(mk_word(ACT_PUSH, 32'h7fff_ffff, 5'd0));
    send_word(mk_word(ACT_PUSH, 32'h8000_0000, 5'd31));
    send_word(mk_word(ACT_PUSH, 32'hffff_ffff, 5'd0));
    send_word(mk_word(ACT_PUSH, 32'h0000_0000, 5'd0));
    send_word(mk_word(ACT_PEEK, 32'd0, 5'd0));
    send_word(mk_word(ACT_PEEK, 32'd0, 5'd1));
    send_word(mk_word(ACT_PEEK, 32'd0, 5'd4));
    send_word(mk_word(ACT_PEEK, 32'd0, 5'd5));
    send_word(mk_word(ACT_PEEK, 32'hffff_ffff, 5'd31));
    send_word(mk_word(ACT_TOP, 32'd0, 5'd0));
    send_word(mk_word(ACT_BOTTOM, 32'd0, 5'd0));
    send_word(mk_word(ACT_UNUSED_LO, 32'd9, 5'd3));
    send_word(mk_word(ACT_UNUSED_MID, 32'd9, 5'd3));
    send_word(mk_word(ACT_UNUSED_HI, 32'd9, 5'd3));
    send_word(mk_word(ACT_POP, 32'd0, 5'd0));
    send_word(mk_word(ACT_POP, 32'd0, 5'd0));

    // Capacity lowered below the fill: full until pops bring it down
    write_capacity(5'd1);
    send_word(mk_word(ACT_PUSH, 32'd11, 5'd0));
    send_word(mk_word(ACT_POP, 32'd0, 5'd0));
    send_word(mk_word(ACT_POP, 32'd0, 5'd0));
    send_word(mk_word(ACT_PUSH, 32'd12, 5'd0));
    send_word(mk_word(ACT_PUSH, 32'd13, 5'd0));

    // Capacity zero acts as one
    write_capacity(5'd0);
    send_word(mk_word(ACT_PUSH, 32'd14, 5'd0));
    send_word(mk_word(ACT_POP, 32'd0, 5'd0));
    send_word(mk_word(ACT_PUSH, 32'd15, 5'd0));
    send_word(mk_word(ACT_PUSH, 32'd16, 5'd0));

    // Random phases over several capacities; the first one runs against a long hold-off
    for (int i = 0; i < 10; i++) begin
      write_capacity(caps[i]);
      if (i == 0) hold_off_req = 1'b1;
      run_random(PHASE_WORDS, (i % 3) != 0);
    end
    pause_sender(1);

    waited = 0;
    while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    sb.errors += sb.pending_results.size();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
